@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/gjmi_pkg.sv @@
// Package for the Gauss-Jordan inverse unit: sizes, states and shared types.
// No dependencies.
package gjmi_pkg;
    localparam int MAX_DIM = 4;
    localparam int FRAC_BITS = 16;
    localparam int ROW_WORDS = 2 * MAX_DIM;
    localparam int DEPTH = MAX_DIM * ROW_WORDS;
    localparam int AW = $clog2(DEPTH);
    localparam int RW = $clog2(MAX_DIM + 1);
    localparam int CW = $clog2(ROW_WORDS + 1);
    localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);
    localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [4:0] {
        ST_LOAD, ST_IDENT, ST_SRCH_RD, ST_SRCH_CHK, ST_SWP_RDA, ST_SWP_RDB, ST_SWP_WRA,
        ST_SWP_WRB, ST_PIV_RD, ST_PIV_DIV, ST_PIV_WAIT, ST_SCL_RD, ST_SCL_MUL, ST_SCL_WR,
        ST_FAC_RD, ST_FAC_LAT, ST_CLR_RDA, ST_CLR_RDB, ST_CLR_MUL, ST_CLR_WR,
        ST_OUT_RD, ST_OUT_LAT, ST_OUT_WAIT, ST_SING
    } state_t;

    typedef struct packed {
        logic start;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic [31:0] quot;
    } div_rsp_t;

    function automatic logic [31:0] sat64(input logic signed [63:0] v);
        if (v > 64'sh7fff_ffff) return SAT_MAX;
        if (v < -64'sh8000_0000) return SAT_MIN;
        return v[31:0];
    endfunction
endpackage

@@ rtl/gjmi_recip.sv @@
// Iterative reciprocal unit: 2^(2*FRAC_BITS) / divisor, one quotient bit a cycle.
// Depends on gjmi_pkg and assert_macros.svh.
`include "assert_macros.svh"
module gjmi_recip (
    input  logic clk,
    input  logic rst_n,
    input  gjmi_pkg::div_req_t req,
    output gjmi_pkg::div_rsp_t rsp
);
    import gjmi_pkg::*;
    localparam int NB = 2 * FRAC_BITS + 1;
    localparam int SB = $clog2(NB + 1);

    logic busy_reg, busy_next, done_reg, done_next, neg_reg, neg_next;
    logic [SB-1:0] cnt_reg, cnt_next;
    logic [32:0] rem_reg, rem_next, dv_reg, dv_next;
    logic [NB-1:0] q_reg, q_next;
    logic [33:0] trial;
    logic signed [63:0] sq;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        dv_next = dv_reg;
        q_next = q_reg;
        trial = {rem_reg, (cnt_reg == SB'(NB)) ? 1'b1 : 1'b0} - {1'b0, dv_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            neg_next = req.divisor[31];
            dv_next = req.divisor[31] ? 33'(-{1'b1, req.divisor}) : {1'b0, req.divisor};
            rem_next = '0;
            q_next = '0;
            cnt_next = SB'(NB);
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                rem_next = trial[32:0];
                q_next = {q_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[31:0], (cnt_reg == SB'(NB)) ? 1'b1 : 1'b0};
                q_next = {q_reg[NB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SB'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dv_reg <= dv_next;
        q_reg <= q_next;
    end

    assign sq = neg_reg ? -$signed(64'(q_reg)) : $signed(64'(q_reg));
    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = sat64(sq);

    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg)
    `ASSERT_IMPL(a_no_start_busy, clk, rst_n, busy_reg, !req.start)
endmodule

@@ rtl/gauss_jordan_matrix_inverse_unit.sv @@
// Top level of the Gauss-Jordan inverse unit: store, sequencer, shared multiplier.
// Depends on gjmi_pkg, gjmi_recip and assert_macros.svh.
// Channel  | Signals                                      | Direction
// input    | element_valid/ready, element_value           | in
// result   | result_valid/ready, result_value, singular,  | out
//          | last_of_run                                  |
// config   | psel penable pwrite paddr pwdata prdata      | in/out
// Loading accepts one element per cycle. Elimination runs on one shared multiplier
// and a bit-serial reciprocal. Each result is read, latched and registered in turn;
// a result stall holds it in ST_OUT_LAT. Reset clears the state and load counters;
// the store is not cleared. The input is not ready during elimination and output.
`include "assert_macros.svh"
module gauss_jordan_matrix_inverse_unit (
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [0:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    input  logic element_valid,
    output logic element_ready,
    input  logic signed [31:0] element_value,
    output logic result_valid,
    input  logic result_ready,
    output logic signed [31:0] result_value,
    output logic singular,
    output logic last_of_run
);
    import gjmi_pkg::*;

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_reg;
    logic [AW-1:0] raddr, waddr;
    logic we;
    logic [31:0] wdata;

    state_t st_reg, st_next;
    logic [3:0] dim_reg;
    logic [6:0] lc_reg, lc_next;
    logic [RW-1:0] n;
    logic [RW-1:0] col_reg, col_next, p_reg, p_next, i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [31:0] a_reg, a_next, f_reg, f_next, rc_reg, rc_next;
    logic signed [63:0] prod_reg, prod_next;
    logic [31:0] ov_reg, ov_next;
    logic os_reg, os_next, ol_reg, ol_next, ovld_reg, ovld_next;
    logic [RW-1:0] lr_reg, lr_next, lcn_reg, lcn_next;
    div_req_t dreq;
    div_rsp_t drsp;
    logic cfg_wr;
    logic signed [63:0] rnd, diff;

    gjmi_recip u_recip (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    function automatic logic [AW-1:0] adr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        return AW'((32'(r) * ROW_WORDS + 32'(c)) % DEPTH);
    endfunction

    assign n = (dim_reg == 4'd0) ? RW'(1) :
               (32'(dim_reg) > MAX_DIM) ? RW'(MAX_DIM) : dim_reg[RW-1:0];
    assign cfg_wr = psel && penable && pwrite && paddr == 1'b0;
    assign pready = 1'b1;
    assign prdata = {28'd0, dim_reg};
    assign rnd = prod_reg + (64'sd1 <<< (FRAC_BITS - 1));

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_comb
    begin
        st_next = st_reg;
        lc_next = lc_reg;
        col_next = col_reg;
        p_next = p_reg;
        i_next = i_reg;
        j_next = j_reg;
        a_next = a_reg;
        f_next = f_reg;
        rc_next = rc_reg;
        prod_next = prod_reg;
        ov_next = ov_reg;
        os_next = os_reg;
        ol_next = ol_reg;
        ovld_next = ovld_reg;
        lr_next = lr_reg;
        lcn_next = lcn_reg;
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;
        dreq.start = 1'b0;
        dreq.divisor = rd_reg;
        element_ready = 1'b0;
        diff = $signed({{32{a_reg[31]}}, a_reg}) - (rnd >>> FRAC_BITS);
        if (ovld_reg && result_ready)
        begin
            ovld_next = 1'b0;
        end
        unique case (st_reg)
            ST_LOAD:
            begin
                element_ready = 1'b1;
                if (element_valid)
                begin
                    we = 1'b1;
                    waddr = adr(lr_reg, CW'(lcn_reg));
                    wdata = element_value;
                    if (lcn_reg == n - 1'b1)
                    begin
                        lcn_next = '0;
                        lr_next = lr_reg + 1'b1;
                    end
                    else
                    begin
                        lcn_next = lcn_reg + 1'b1;
                    end
                    lc_next = lc_reg + 1'b1;
                    if (lc_reg == 7'(n * n - 1))
                    begin
                        lc_next = '0;
                        lr_next = '0;
                        lcn_next = '0;
                        i_next = '0;
                        j_next = '0;
                        st_next = ST_IDENT;
                    end
                end
            end
            ST_IDENT:
            begin
                we = 1'b1;
                waddr = adr(i_reg, CW'(n) + j_reg);
                wdata = (j_reg == CW'(i_reg)) ? ONE_Q : '0;
                if (j_reg == CW'(n - 1'b1))
                begin
                    j_next = '0;
                    i_next = i_reg + 1'b1;
                    if (i_reg == n - 1'b1)
                    begin
                        col_next = '0;
                        p_next = '0;
                        st_next = ST_SRCH_RD;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_SRCH_RD:
            begin
                raddr = adr(p_reg, CW'(col_reg));
                st_next = ST_SRCH_CHK;
            end
            ST_SRCH_CHK:
            begin
                if (rd_reg != '0)
                begin
                    j_next = '0;
                    st_next = (p_reg == col_reg) ? ST_PIV_RD : ST_SWP_RDA;
                end
                else if (p_reg == n - 1'b1)
                begin
                    st_next = ST_SING;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                    st_next = ST_SRCH_RD;
                end
            end
            ST_SWP_RDA:
            begin
                raddr = adr(p_reg, j_reg);
                st_next = ST_SWP_RDB;
            end
            ST_SWP_RDB:
            begin
                raddr = adr(col_reg, j_reg);
                a_next = rd_reg;
                st_next = ST_SWP_WRA;
            end
            ST_SWP_WRA:
            begin
                we = 1'b1;
                waddr = adr(p_reg, j_reg);
                wdata = rd_reg;
                st_next = ST_SWP_WRB;
            end
            ST_SWP_WRB:
            begin
                we = 1'b1;
                waddr = adr(col_reg, j_reg);
                wdata = a_reg;
                if (j_reg == CW'(2 * n - 1'b1))
                begin
                    j_next = '0;
                    st_next = ST_PIV_RD;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    st_next = ST_SWP_RDA;
                end
            end
            ST_PIV_RD:
            begin
                raddr = adr(col_reg, CW'(col_reg));
                st_next = ST_PIV_DIV;
            end
            ST_PIV_DIV:
            begin
                dreq.start = 1'b1;
                st_next = ST_PIV_WAIT;
            end
            ST_PIV_WAIT:
            begin
                if (drsp.done)
                begin
                    rc_next = drsp.quot;
                    j_next = '0;
                    st_next = ST_SCL_RD;
                end
            end
            ST_SCL_RD:
            begin
                raddr = adr(col_reg, j_reg);
                st_next = ST_SCL_MUL;
            end
            ST_SCL_MUL:
            begin
                prod_next = $signed(rd_reg) * $signed(rc_reg);
                st_next = ST_SCL_WR;
            end
            ST_SCL_WR:
            begin
                we = 1'b1;
                waddr = adr(col_reg, j_reg);
                wdata = (j_reg == CW'(col_reg)) ? ONE_Q : sat64(rnd >>> FRAC_BITS);
                if (j_reg == CW'(2 * n - 1'b1))
                begin
                    i_next = '0;
                    st_next = ST_FAC_RD;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    st_next = ST_SCL_RD;
                end
            end
            ST_FAC_RD:
            begin
                if (i_reg == n)
                begin
                    if (col_reg == n - 1'b1)
                    begin
                        i_next = '0;
                        j_next = '0;
                        st_next = ST_OUT_RD;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                        p_next = col_reg + 1'b1;
                        st_next = ST_SRCH_RD;
                    end
                end
                else if (i_reg == col_reg)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    raddr = adr(i_reg, CW'(col_reg));
                    st_next = ST_FAC_LAT;
                end
            end
            ST_FAC_LAT:
            begin
                f_next = rd_reg;
                j_next = '0;
                st_next = ST_CLR_RDA;
            end
            ST_CLR_RDA:
            begin
                raddr = adr(col_reg, j_reg);
                st_next = ST_CLR_RDB;
            end
            ST_CLR_RDB:
            begin
                raddr = adr(i_reg, j_reg);
                prod_next = $signed(f_reg) * $signed(rd_reg);
                st_next = ST_CLR_MUL;
            end
            ST_CLR_MUL:
            begin
                a_next = rd_reg;
                st_next = ST_CLR_WR;
            end
            ST_CLR_WR:
            begin
                we = 1'b1;
                waddr = adr(i_reg, j_reg);
                wdata = (j_reg == CW'(col_reg)) ? '0 : sat64(diff);
                if (j_reg == CW'(2 * n - 1'b1))
                begin
                    i_next = i_reg + 1'b1;
                    st_next = ST_FAC_RD;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                    st_next = ST_CLR_RDA;
                end
            end
            ST_OUT_RD:
            begin
                raddr = adr(i_reg, CW'(n) + j_reg);
                st_next = ST_OUT_LAT;
            end
            ST_OUT_LAT:
            begin
                raddr = adr(i_reg, CW'(n) + j_reg);
                if (!ovld_reg || result_ready)
                begin
                    ovld_next = 1'b1;
                    ov_next = rd_reg;
                    os_next = 1'b0;
                    ol_next = (i_reg == n - 1'b1) && (j_reg == CW'(n - 1'b1));
                    st_next = ST_OUT_WAIT;
                end
            end
            ST_OUT_WAIT:
            begin
                if (ol_reg)
                begin
                    st_next = ST_LOAD;
                end
                else
                begin
                    if (j_reg == CW'(n - 1'b1))
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    st_next = ST_OUT_RD;
                end
            end
            ST_SING:
            begin
                if (!ovld_reg || result_ready)
                begin
                    ovld_next = 1'b1;
                    ov_next = '0;
                    os_next = 1'b1;
                    ol_next = 1'b1;
                    st_next = ST_LOAD;
                end
            end
            default:
            begin
                st_next = ST_LOAD;
            end
        endcase
        if (cfg_wr)
        begin
            lc_next = '0;
            lr_next = '0;
            lcn_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_LOAD;
            dim_reg <= 4'd4;
            lc_reg <= '0;
            lr_reg <= '0;
            lcn_reg <= '0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            lc_reg <= lc_next;
            lr_reg <= lr_next;
            lcn_reg <= lcn_next;
            ovld_reg <= ovld_next;
            if (cfg_wr)
            begin
                dim_reg <= pwdata[3:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        p_reg <= p_next;
        i_reg <= i_next;
        j_reg <= j_next;
        a_reg <= a_next;
        f_reg <= f_next;
        rc_reg <= rc_next;
        prod_reg <= prod_next;
        ov_reg <= ov_next;
        os_reg <= os_next;
        ol_reg <= ol_next;
    end

    assign result_valid = ovld_reg;
    assign result_value = ov_reg;
    assign singular = os_reg;
    assign last_of_run = ol_reg;

    `ASSERT_IMPL(a_ready_load, clk, rst_n, element_ready, st_reg == ST_LOAD)
    `ASSERT_IMPL(a_sing_last, clk, rst_n, result_valid && singular, last_of_run)
    `ASSERT_NEXT(a_start_idle, clk, rst_n, st_reg == ST_PIV_DIV, drsp.busy)
endmodule
